// ===== design/ssra_pkg.sv =====
package ssra_pkg;

  localparam int CNT_W   = 13;
  localparam int SLOT_W  = 12;
  localparam int COUNT_W = 8;
  localparam int OVF_W   = 32;
  localparam int SLOT_CAP = 4096;

  localparam logic [COUNT_W-1:0] STICKY     = 8'd255;
  localparam logic [COUNT_W-1:0] FRESH_REFS = 8'd2;
  localparam logic [CNT_W-1:0]   FREE_MAX   = 13'd8191;
  localparam logic [OVF_W-1:0]   OVF_DEC    = ~32'd0;
  localparam logic [OVF_W-1:0]   OVF_INC    = 32'd1;
  localparam logic [OVF_W-1:0]   OVF_BULK   = 32'd255;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_RELEASE,
    K_DUP,
    K_QUERY
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_FREE,
    ST_BAD_SLOT,
    ST_OVF_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             load;
    logic             run;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] lim;
  } scan_ctl_t;

  typedef struct packed {
    logic             issue;
    logic [CNT_W-1:0] pos;
    logic             rd_vld;
    logic [CNT_W-1:0] rd_pos;
    logic             left_zero;
  } scan_sts_t;

endpackage

// ===== design/ssra_if.sv =====
interface ssra_req_if;
  import ssra_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, kind, slot, input ready);
  modport sink   (input valid, kind, slot, output ready);
endinterface

interface ssra_rsp_if;
  import ssra_pkg::*;
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  given_slot;
  logic [COUNT_W-1:0] ref_count;
  logic [CNT_W-1:0]   free_slots;
  logic [1:0]         status;

  modport source (output valid, given_slot, ref_count, free_slots, status, input ready);
  modport sink   (input valid, given_slot, ref_count, free_slots, status, output ready);
endinterface

// ===== design/swap_slot_refcount_allocator_core.sv =====
// Swap slot reference-count allocator. Each slot holds an 8-bit reference
// count in a single-port-write / single-port-read RAM; a sequencer walks it
// one entry per cycle through a shared scan unit. Allocate searches next-fit
// from the hint for a zero count, sets it to 2 and returns the slot; release
// lowers a count, duplicate raises it, query reads it. A count of 255 is
// sticky and spills into a shared 32-bit overflow counter; when that counter
// drains to zero, every sticky slot in the active range is cleared and freed.
// After reset a clearing pass writes zero to all NUM_SLOTS entries while
// req.ready is low (slots_in_use writes are still taken). Release, duplicate
// and query pass through the read, execute and finish states; a slot outside
// the active range goes straight to finish. Allocate reads entries through
// the scan unit until a zero count is found, at most the active limit of
// them; allocate with no free slot counted goes straight to finish. A release
// that drains the overflow counter adds a sweep over the active range. A
// finished result waits in the output register, so the next item is taken
// while the previous one is still not collected. Write slots_in_use only
// while idle; it reloads the free count and pulls the hint back inside the
// new range.
module swap_slot_refcount_allocator_core #(
  parameter int NUM_SLOTS = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  ssra_req_if.sink                   req,
  ssra_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic [ssra_pkg::CNT_W-1:0] cfg_data
);
  import ssra_pkg::*;

  localparam int AW      = $clog2(NUM_SLOTS);
  localparam int LIM_MAX = (NUM_SLOTS < SLOT_CAP) ? NUM_SLOTS : SLOT_CAP;

  // clamp the slot count to the built store, zero counts as one
  function automatic logic [CNT_W-1:0] active_lim(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] l;
    l = (v > CNT_W'(LIM_MAX)) ? CNT_W'(LIM_MAX) : v;
    if (l == '0) begin
      l = CNT_W'(1);
    end
    return l;
  endfunction

  state_t             state, state_next;
  logic [AW-1:0]      clr, clr_next;
  logic [CNT_W-1:0]   slots_in_use, slots_in_use_next;
  logic [CNT_W-1:0]   free_total, free_total_next;
  logic [SLOT_W-1:0]  hint, hint_next;
  logic [OVF_W-1:0]   ovf, ovf_next;
  kind_t              op_kind, op_kind_next;
  logic [SLOT_W-1:0]  op_slot, op_slot_next;
  logic [SLOT_W-1:0]  res_given, res_given_next;
  logic [COUNT_W-1:0] res_count, res_count_next;
  status_t            res_status, res_status_next;

  logic               out_valid;
  logic [SLOT_W-1:0]  out_given;
  logic [COUNT_W-1:0] out_count;
  logic [CNT_W-1:0]   out_free;
  status_t            out_status;
  logic               out_load;

  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   cfg_lim;
  logic [CNT_W-1:0]   free_inc;
  logic [OVF_W-1:0]   ovf_addend;
  logic [OVF_W-1:0]   ovf_sum;
  logic               accept;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;

  scan_ctl_t          scan_ctl;
  scan_sts_t          scan_sts;

  ssra_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_SLOTS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ssra_scan u_scan (
    .clk (clk),
    .rst (rst),
    .ctl (scan_ctl),
    .sts (scan_sts)
  );

  assign lim      = active_lim(slots_in_use);
  assign cfg_lim  = active_lim(cfg_data);
  assign free_inc = (free_total == FREE_MAX) ? free_total : free_total + 1'b1;
  // one shared adder serves every overflow counter update
  assign ovf_sum  = ovf + ovf_addend;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next        = state;
    clr_next          = clr;
    slots_in_use_next = slots_in_use;
    free_total_next   = free_total;
    hint_next         = hint;
    ovf_next          = ovf;
    op_kind_next      = op_kind;
    op_slot_next      = op_slot;
    res_given_next    = res_given;
    res_count_next    = res_count;
    res_status_next   = res_status;
    out_load          = 1'b0;
    ovf_addend        = OVF_INC;
    ram_we            = 1'b0;
    ram_waddr         = AW'(op_slot);
    ram_wdata         = '0;
    ram_raddr         = AW'(op_slot);
    scan_ctl.load     = 1'b0;
    scan_ctl.run      = 1'b0;
    scan_ctl.start    = '0;
    scan_ctl.lim      = lim;

    case (state)
      S_CLEAR: begin
        // sweep the whole store to zero
        ram_we    = 1'b1;
        ram_waddr = clr;
        clr_next  = clr + 1'b1;
        if (clr == AW'(NUM_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_kind_next    = kind_t'(req.kind);
          op_slot_next    = req.slot;
          res_given_next  = '0;
          res_count_next  = '0;
          res_status_next = ST_OK;
          if (kind_t'(req.kind) == K_ALLOC) begin
            if (free_total == '0) begin
              res_status_next = ST_NO_FREE;
              state_next      = S_FINISH;
            end else begin
              // start at the hint, or at zero if it fell out of range
              scan_ctl.load  = 1'b1;
              scan_ctl.start = ({1'b0, hint} < lim) ? {1'b0, hint} : '0;
              state_next     = S_SCAN;
            end
          end else if ({1'b0, req.slot} >= lim) begin
            res_status_next = ST_BAD_SLOT;
            state_next      = S_FINISH;
          end else begin
            state_next = S_READ;
          end
        end
      end

      S_READ: begin
        ram_raddr  = AW'(op_slot);
        state_next = S_EXEC;
      end

      S_EXEC: begin
        state_next = S_FINISH;
        case (op_kind)
          K_RELEASE: begin
            if (ram_rdata == '0) begin
              res_status_next = ST_BAD_SLOT;
            end else if (ram_rdata == STICKY) begin
              if (ovf == '0) begin
                res_status_next = ST_OVF_EMPTY;
                res_count_next  = STICKY;
              end else begin
                ovf_addend = OVF_DEC;
                ovf_next   = ovf_sum;
                if (ovf == OVF_INC) begin
                  // last overflow reference gone: free every sticky slot
                  res_count_next = '0;
                  scan_ctl.load  = 1'b1;
                  scan_ctl.start = '0;
                  state_next     = S_DRAIN;
                end else begin
                  res_count_next = STICKY;
                end
              end
            end else begin
              ram_we         = 1'b1;
              ram_wdata      = ram_rdata - 1'b1;
              res_count_next = ram_rdata - 1'b1;
              if (ram_rdata == COUNT_W'(1)) begin
                free_total_next = free_inc;
              end
            end
          end
          K_DUP: begin
            if (ram_rdata == STICKY) begin
              ovf_addend     = OVF_INC;
              ovf_next       = ovf_sum;
              res_count_next = STICKY;
            end else begin
              ram_we         = 1'b1;
              ram_wdata      = ram_rdata + 1'b1;
              res_count_next = ram_rdata + 1'b1;
              if (ram_rdata == STICKY - 1'b1) begin
                ovf_addend = OVF_BULK;
                ovf_next   = ovf_sum;
              end
            end
          end
          default: begin
            res_count_next = ram_rdata;
          end
        endcase
      end

      S_SCAN: begin
        scan_ctl.run = 1'b1;
        ram_raddr    = AW'(scan_sts.pos);
        if (scan_sts.rd_vld && (ram_rdata == '0)) begin
          ram_we          = 1'b1;
          ram_waddr       = AW'(scan_sts.rd_pos);
          ram_wdata       = FRESH_REFS;
          hint_next       = scan_sts.rd_pos[SLOT_W-1:0];
          free_total_next = free_total - 1'b1;
          res_given_next  = scan_sts.rd_pos[SLOT_W-1:0];
          res_count_next  = FRESH_REFS;
          state_next      = S_FINISH;
        end else if (scan_sts.rd_vld && scan_sts.left_zero) begin
          res_status_next = ST_NO_FREE;
          state_next      = S_FINISH;
        end
      end

      S_DRAIN: begin
        scan_ctl.run = 1'b1;
        ram_raddr    = AW'(scan_sts.pos);
        if (scan_sts.rd_vld && (ram_rdata == STICKY)) begin
          ram_we          = 1'b1;
          ram_waddr       = AW'(scan_sts.rd_pos);
          ram_wdata       = '0;
          free_total_next = free_inc;
        end
        if (scan_sts.rd_vld && scan_sts.left_zero) begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // the user must write configuration only while idle; the block does not enforce it
    if (cfg_we) begin
      slots_in_use_next = cfg_data;
      free_total_next   = cfg_lim;
      if ({1'b0, hint} >= cfg_lim) begin
        hint_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr          <= '0;
      slots_in_use <= CNT_W'(SLOT_CAP);
      free_total   <= CNT_W'(LIM_MAX);
      hint         <= '0;
      ovf          <= '0;
      out_valid    <= 1'b0;
    end else begin
      clr          <= clr_next;
      slots_in_use <= slots_in_use_next;
      free_total   <= free_total_next;
      hint         <= hint_next;
      ovf          <= ovf_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_kind    <= op_kind_next;
    op_slot    <= op_slot_next;
    res_given  <= res_given_next;
    res_count  <= res_count_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_given  <= res_given;
      out_count  <= res_count;
      out_free   <= free_total;
      out_status <= res_status;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.given_slot = out_given;
  assign rsp.ref_count  = out_count;
  assign rsp.free_slots = out_free;
  assign rsp.status     = out_status;

  // the drain sweep starts only once the overflow counter has reached zero
  a_drain_ovf_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (ovf == '0))
    else $error("drain sweep with overflow references outstanding");

  // a search never runs with no free slot counted
  a_scan_has_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (free_total != '0))
    else $error("slot search started with free count zero");

  // an accepted item lowers req.ready so that the next one is blocked
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item accepted while one is in flight");

  // a granted slot always lies inside the active range
  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_load && (res_status == ST_OK) && (op_kind == K_ALLOC))
      |-> ({1'b0, res_given} < lim))
    else $error("allocate granted a slot beyond the active limit");

endmodule

// ===== design/ssra_ram.sv =====
module ssra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ssra_scan.sv =====
module ssra_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  ssra_pkg::scan_ctl_t  ctl,
  output ssra_pkg::scan_sts_t  sts
);
  import ssra_pkg::*;

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] left;
  logic [CNT_W-1:0] rd_pos;
  logic             rd_vld;
  logic             issue;
  logic [CNT_W-1:0] pos_inc;
  logic [CNT_W-1:0] pos_next;

  assign issue    = ctl.run && (left != '0);
  assign pos_inc  = pos + 1'b1;
  // wrap to slot zero at the end of the active range
  assign pos_next = (pos_inc == ctl.lim) ? '0 : pos_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      left   <= '0;
      rd_vld <= 1'b0;
    end else if (ctl.load) begin
      pos    <= ctl.start;
      left   <= ctl.lim;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        pos    <= pos_next;
        left   <= left - 1'b1;
        rd_pos <= pos;
      end
    end
  end

  assign sts.issue     = issue;
  assign sts.pos       = pos;
  assign sts.rd_vld    = rd_vld;
  assign sts.rd_pos    = rd_pos;
  assign sts.left_zero = (left == '0);

endmodule
